FILE: src/dccpp_pkg.sv
// ----------------------------------------------------------------------------
// dccpp_pkg
// Shared widths, register indexes, reset values and types for the duty
// cycled window capture with ping-pong banks.
// ----------------------------------------------------------------------------
`default_nettype none

package dccpp_pkg;

    // field widths
    localparam int PERIOD_W   = 20;
    localparam int WIN_W      = 16;
    localparam int WPB_W      = 16;
    localparam int CHAN_W     = 3;
    localparam int ADDR_W     = 23;
    localparam int SAMPLE_W   = 32;
    localparam int LANES      = 4;
    localparam int MAX_CHANNELS = 4;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_LENGTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOWS_PER_BLOCK = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_CHANNELS   = 2'd3;

    // register reset values
    localparam logic [PERIOD_W-1:0] RST_PERIOD_LENGTH     = PERIOD_W'(1000);
    localparam logic [WIN_W-1:0]    RST_WINDOW_LENGTH     = WIN_W'(500);
    localparam logic [WPB_W-1:0]    RST_WINDOWS_PER_BLOCK = WPB_W'(1000 * 10);
    localparam logic [CHAN_W-1:0]   RST_ACTIVE_CHANNELS   = CHAN_W'(4);

    typedef logic [LANES-1:0][SAMPLE_W-1:0] t_lanes;

    // effective configuration seen by the datapath
    typedef struct packed {
        logic [PERIOD_W-1:0] per;
        logic [WIN_W-1:0]    win;
        logic [WPB_W-1:0]    wpb;
        logic [CHAN_W-1:0]   active;
    } t_cfg;

    // classified request passed from front to back
    typedef struct packed {
        logic              wr_en;
        logic              bank;
        logic [WIN_W-1:0]  pos;
        logic [WPB_W-1:0]  wc;
        t_lanes            data;
        logic              ready;
        logic              ready_bank;
        logic              dropped;
    } t_item;

    // finished result
    typedef struct packed {
        logic              wr_en;
        logic              bank;
        logic [ADDR_W-1:0] addr;
        t_lanes            data;
        logic              ready;
        logic              ready_bank;
        logic              dropped;
    } t_result;

endpackage

`default_nettype wire

FILE: src/duty_cycled_capture_ping_pong.sv
// Path: a result passes through the request queue, then the address/output register,
//   and is held there until it is taken.
// Throughput: one sample per cycle while o_stall is low; the position and window
//   counters in the front part update per sample, the address multiply sits in the back.
// Reset: synchronous, active low; counters, bank, queue and output valid clear
//   and the configuration registers return to their defaults.
// ----------------------------------------------------------------------------
// duty_cycled_capture_ping_pong
// Periodic window capture into two ping-pong banks with hand-over and drop
// reporting.
// ----------------------------------------------------------------------------
`default_nettype none

module duty_cycled_capture_ping_pong import dccpp_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // sample channel
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [SAMPLE_W-1:0]   i_sample_ch0,
    input  wire logic [SAMPLE_W-1:0]   i_sample_ch1,
    input  wire logic [SAMPLE_W-1:0]   i_sample_ch2,
    input  wire logic [SAMPLE_W-1:0]   i_sample_ch3,
    input  wire logic                  i_consumer_idle,
    // write channel
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic                       o_write_enable,
    output logic                       o_write_bank,
    output logic [ADDR_W-1:0]          o_write_address,
    output logic [SAMPLE_W-1:0]        o_data_ch0,
    output logic [SAMPLE_W-1:0]        o_data_ch1,
    output logic [SAMPLE_W-1:0]        o_data_ch2,
    output logic [SAMPLE_W-1:0]        o_data_ch3,
    output logic                       o_block_ready,
    output logic                       o_ready_bank,
    output logic                       o_block_dropped
);

    logic [PERIOD_W-1:0] r_period_length;
    logic [WIN_W-1:0]    r_window_length;
    logic [WPB_W-1:0]    r_windows_per_block;
    logic [CHAN_W-1:0]   r_active_channels;

    t_cfg    cfg;
    t_lanes  samples;
    t_item   push_item;
    t_item   head;
    t_result result;
    logic    push;
    logic    pop;
    logic    full;
    logic    empty;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_length     <= RST_PERIOD_LENGTH;
            r_window_length     <= RST_WINDOW_LENGTH;
            r_windows_per_block <= RST_WINDOWS_PER_BLOCK;
            r_active_channels   <= RST_ACTIVE_CHANNELS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PERIOD_LENGTH:     r_period_length     <= i_cfg_wdata[PERIOD_W-1:0];
                CFG_WINDOW_LENGTH:     r_window_length     <= i_cfg_wdata[WIN_W-1:0];
                CFG_WINDOWS_PER_BLOCK: r_windows_per_block <= i_cfg_wdata[WPB_W-1:0];
                CFG_ACTIVE_CHANNELS:   r_active_channels   <= i_cfg_wdata[CHAN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // effective values: zero window or block acts as one, short period as window
    always_comb begin
        cfg.win    = (r_window_length == '0) ? WIN_W'(1) : r_window_length;
        cfg.per    = (r_period_length < PERIOD_W'(cfg.win)) ? PERIOD_W'(cfg.win)
                                                            : r_period_length;
        cfg.wpb    = (r_windows_per_block == '0) ? WPB_W'(1) : r_windows_per_block;
        cfg.active = r_active_channels;
    end

    assign samples[0] = i_sample_ch0;
    assign samples[1] = i_sample_ch1;
    assign samples[2] = i_sample_ch2;
    assign samples[3] = i_sample_ch3;

    dccpp_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_valid         (i_valid),
        .i_samples       (samples),
        .i_consumer_idle (i_consumer_idle),
        .i_full          (full),
        .o_stall         (o_stall),
        .o_push          (push),
        .o_item          (push_item)
    );

    dccpp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    dccpp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_win    (cfg.win),
        .i_empty  (empty),
        .i_head   (head),
        .i_stall  (i_stall),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .o_result (result)
    );

    // result breakout
    assign o_write_enable  = result.wr_en;
    assign o_write_bank    = result.bank;
    assign o_write_address = result.addr;
    assign o_data_ch0      = result.data[0];
    assign o_data_ch1      = result.data[1];
    assign o_data_ch2      = result.data[2];
    assign o_data_ch3      = result.data[3];
    assign o_block_ready   = result.ready;
    assign o_ready_bank    = result.ready_bank;
    assign o_block_dropped = result.dropped;

endmodule

`default_nettype wire

FILE: src/dccpp_front.sv
// ----------------------------------------------------------------------------
// dccpp_front
// Tracks period position, window count and current bank; classifies each
// sample and pushes a request into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dccpp_front import dccpp_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_cfg   i_cfg,
    input  wire logic   i_valid,
    input  wire t_lanes i_samples,
    input  wire logic   i_consumer_idle,
    input  wire logic   i_full,
    output logic        o_stall,
    output logic        o_push,
    output t_item       o_item
);

    logic [PERIOD_W-1:0] r_pos;
    logic [WPB_W-1:0]    r_wc;
    logic                r_bank;
    logic [PERIOD_W-1:0] n_pos;
    logic [WPB_W-1:0]    n_wc;
    logic                n_bank;

    logic                in_win;
    logic                last;
    logic                complete;
    logic [PERIOD_W:0]   pos_inc;
    logic [WPB_W-1:0]    wc_inc;
    logic [LANES-1:0]    lane_en;

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    // classify the sample and work out the next counter values
    always_comb begin
        in_win   = r_pos < PERIOD_W'(i_cfg.win);
        pos_inc  = {1'b0, r_pos} + (PERIOD_W + 1)'(1);
        last     = in_win && (pos_inc == (PERIOD_W + 1)'(i_cfg.win));
        wc_inc   = r_wc + WPB_W'(1);
        complete = last && (wc_inc >= i_cfg.wpb);

        n_wc   = last ? (complete ? '0 : wc_inc) : r_wc;
        n_bank = r_bank ^ (complete && i_consumer_idle);
        n_pos  = (pos_inc >= (PERIOD_W + 1)'(i_cfg.per)) ? '0 : pos_inc[PERIOD_W-1:0];

        for (int k = 0; k < LANES; k++) begin
            lane_en[k] = (k == 0) || ((k < int'(i_cfg.active)) && (k < MAX_CHANNELS));
        end

        o_item.wr_en      = in_win;
        o_item.bank       = r_bank;
        o_item.pos        = r_pos[WIN_W-1:0];
        o_item.wc         = r_wc;
        o_item.ready      = complete && i_consumer_idle;
        o_item.ready_bank = complete && i_consumer_idle && r_bank;
        o_item.dropped    = complete && !i_consumer_idle;
        for (int k = 0; k < LANES; k++) begin
            o_item.data[k] = (in_win && lane_en[k]) ? i_samples[k] : '0;
        end
    end

    // counter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_wc   <= '0;
            r_bank <= 1'b0;
        end else if (o_push) begin
            r_pos  <= n_pos;
            r_wc   <= n_wc;
            r_bank <= n_bank;
        end
    end

endmodule

`default_nettype wire

FILE: src/dccpp_queue.sv
// ----------------------------------------------------------------------------
// dccpp_queue
// Two-entry request queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module dccpp_queue import dccpp_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    input  wire logic  i_pop,
    output logic       o_full,
    output logic       o_empty,
    output t_item      o_head
);

    t_item       r_mem [2];
    logic        r_wptr;
    logic        r_rptr;
    logic [1:0]  r_count;

    assign o_full  = r_count == 2'd2;
    assign o_empty = r_count == 2'd0;
    assign o_head  = r_mem[r_rptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/dccpp_back.sv
// ----------------------------------------------------------------------------
// dccpp_back
// Computes the bank address of each request and holds the result in the
// output register until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dccpp_back import dccpp_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [WIN_W-1:0] i_win,
    input  wire logic             i_empty,
    input  wire t_item            i_head,
    input  wire logic             i_stall,
    output logic                  o_pop,
    output logic                  o_valid,
    output t_result               o_result
);

    logic                      r_valid;
    t_result                   r_result;
    t_result                   n_result;
    logic [WPB_W+WIN_W-1:0]    product;
    logic [ADDR_W-1:0]         addr;

    assign o_pop    = !i_empty && (!r_valid || !i_stall);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // window base plus offset, wrapped to the bank depth
    always_comb begin
        product = (WPB_W + WIN_W)'(i_head.wc) * (WPB_W + WIN_W)'(i_win);
        addr    = product[ADDR_W-1:0] + ADDR_W'(i_head.pos);

        n_result.wr_en      = i_head.wr_en;
        n_result.bank       = i_head.bank;
        n_result.addr       = i_head.wr_en ? addr : '0;
        n_result.data       = i_head.data;
        n_result.ready      = i_head.ready;
        n_result.ready_bank = i_head.ready_bank;
        n_result.dropped    = i_head.dropped;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || !i_stall) begin
            r_valid <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= n_result;
        end
    end

endmodule

`default_nettype wire

FILE: test/tb_duty_cycled_capture_ping_pong.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_duty_cycled_capture_ping_pong
// Self-checking bench for the duty cycled capture block. A directed table
// covers the register extremes and the window, hand-over and drop corners.
// Random phases follow, each with fresh register values. A local model of
// the period position, window count and bank swap predicts every write
// request, and each result is compared field by field. Both request
// channels idle at random.
// ----------------------------------------------------------------------------
module tb_duty_cycled_capture_ping_pong;
    import dccpp_pkg::*;

    localparam int RAND_ITEMS   = 850;
    localparam int DRAIN_CYCLES = 4;

    // one sample request as driven on the input channel
    typedef struct packed {
        logic [SAMPLE_W-1:0] ch0;
        logic [SAMPLE_W-1:0] ch1;
        logic [SAMPLE_W-1:0] ch2;
        logic [SAMPLE_W-1:0] ch3;
        logic                idle;
    } t_sample_req;

    // one write request as seen on the output channel
    typedef struct packed {
        logic                we;
        logic                bank;
        logic [ADDR_W-1:0]   addr;
        logic [SAMPLE_W-1:0] d0;
        logic [SAMPLE_W-1:0] d1;
        logic [SAMPLE_W-1:0] d2;
        logic [SAMPLE_W-1:0] d3;
        logic                ready;
        logic                rbank;
        logic                dropped;
    } t_capture;

    typedef enum logic {ROW_REG, ROW_SAMPLE} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
        t_sample_req           req;
        bit                    known;
        t_capture              want;
    } t_stim_row;

    // dut ports
    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = CFG_PERIOD_LENGTH;
    logic [CFG_DATA_W-1:0] i_cfg_wdata     = '0;
    logic                  i_valid         = 1'b0;
    logic [SAMPLE_W-1:0]   i_sample_ch0    = '0;
    logic [SAMPLE_W-1:0]   i_sample_ch1    = '0;
    logic [SAMPLE_W-1:0]   i_sample_ch2    = '0;
    logic [SAMPLE_W-1:0]   i_sample_ch3    = '0;
    logic                  i_consumer_idle = 1'b0;
    logic                  i_stall         = 1'b0;
    logic                  o_stall;
    logic                  o_valid;
    logic                  o_write_enable;
    logic                  o_write_bank;
    logic [ADDR_W-1:0]     o_write_address;
    logic [SAMPLE_W-1:0]   o_data_ch0;
    logic [SAMPLE_W-1:0]   o_data_ch1;
    logic [SAMPLE_W-1:0]   o_data_ch2;
    logic [SAMPLE_W-1:0]   o_data_ch3;
    logic                  o_block_ready;
    logic                  o_ready_bank;
    logic                  o_block_dropped;

    // model copy of the registers and counters
    logic [PERIOD_W-1:0] cfg_per;
    logic [WIN_W-1:0]    cfg_win;
    logic [WPB_W-1:0]    cfg_wpb;
    logic [CHAN_W-1:0]   cfg_active;
    logic [PERIOD_W-1:0] cap_pos;
    logic [WPB_W-1:0]    win_cnt;
    logic                cur_bank;

    t_capture  pending_writes[$];
    t_stim_row directed_rows[$];

    int src_gap_pct    = 34;
    int sink_stall_pct = 71;
    int fails          = 0;
    int rand_items     = 0;
    int n_samples      = 0;
    int n_writes       = 0;
    int n_handovers    = 0;
    int n_drops        = 0;
    int n_checked      = 0;
    int n_reg_writes   = 0;

    duty_cycled_capture_ping_pong u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_sample_ch0    (i_sample_ch0),
        .i_sample_ch1    (i_sample_ch1),
        .i_sample_ch2    (i_sample_ch2),
        .i_sample_ch3    (i_sample_ch3),
        .i_consumer_idle (i_consumer_idle),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_write_enable  (o_write_enable),
        .o_write_bank    (o_write_bank),
        .o_write_address (o_write_address),
        .o_data_ch0      (o_data_ch0),
        .o_data_ch1      (o_data_ch1),
        .o_data_ch2      (o_data_ch2),
        .o_data_ch3      (o_data_ch3),
        .o_block_ready   (o_block_ready),
        .o_ready_bank    (o_ready_bank),
        .o_block_dropped (o_block_dropped)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // next write request for one sample, advances the model counters
    function automatic t_capture capture_step(t_sample_req r);
        t_capture              c;
        logic [WIN_W-1:0]      eff_win;
        logic [PERIOD_W-1:0]   eff_per;
        logic [WPB_W-1:0]      eff_wpb;
        logic [47:0]           flat_addr;
        logic [PERIOD_W:0]     nxt;
        c = '0;
        c.bank = cur_bank;
        eff_win = (cfg_win == '0) ? WIN_W'(1) : cfg_win;
        eff_per = (cfg_per < PERIOD_W'(eff_win)) ? PERIOD_W'(eff_win) : cfg_per;
        if (cap_pos < PERIOD_W'(eff_win)) begin
            // bank depth is a power of two, so the wrap is the low address bits
            flat_addr = 48'(win_cnt) * 48'(eff_win) + 48'(cap_pos);
            c.we = 1'b1;
            c.addr = flat_addr[ADDR_W-1:0];
            c.d0 = r.ch0;
            if (cfg_active > CHAN_W'(1)) c.d1 = r.ch1;
            if (cfg_active > CHAN_W'(2)) c.d2 = r.ch2;
            if (cfg_active > CHAN_W'(3)) c.d3 = r.ch3;
            // last sample of the window closes it, maybe the whole bank
            if (cap_pos + PERIOD_W'(1) == PERIOD_W'(eff_win)) begin
                eff_wpb = (cfg_wpb == '0) ? WPB_W'(1) : cfg_wpb;
                win_cnt = win_cnt + WPB_W'(1);
                if (win_cnt >= eff_wpb) begin
                    win_cnt = '0;
                    if (r.idle) begin
                        c.ready = 1'b1;
                        c.rbank = cur_bank;
                        cur_bank = ~cur_bank;
                    end else begin
                        c.dropped = 1'b1;
                    end
                end
            end
        end
        // position restarts at the period end, or when a shorter period leaves it behind
        nxt = {1'b0, cap_pos} + (PERIOD_W+1)'(1);
        if (nxt >= {1'b0, eff_per} || cap_pos >= eff_per) nxt = '0;
        cap_pos = nxt[PERIOD_W-1:0];
        return c;
    endfunction

    function automatic t_capture write_of(logic we, logic bank, logic [ADDR_W-1:0] addr,
                                          logic [SAMPLE_W-1:0] d0, logic [SAMPLE_W-1:0] d1,
                                          logic [SAMPLE_W-1:0] d2, logic [SAMPLE_W-1:0] d3,
                                          logic ready, logic rbank, logic dropped);
        return {we, bank, addr, d0, d1, d2, d3, ready, rbank, dropped};
    endfunction

    function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        t_stim_row row;
        row.kind  = ROW_REG;
        row.idx   = idx;
        row.val   = val;
        row.req   = '0;
        row.known = 1'b0;
        row.want  = '0;
        directed_rows = {directed_rows, row};
    endfunction

    function automatic void add_sample(t_sample_req req, bit known, t_capture want);
        t_stim_row row;
        row.kind  = ROW_SAMPLE;
        row.idx   = CFG_PERIOD_LENGTH;
        row.val   = '0;
        row.req   = req;
        row.known = known;
        row.want  = want;
        directed_rows = {directed_rows, row};
    endfunction

    task automatic check_field(string name, logic [SAMPLE_W-1:0] want, logic [SAMPLE_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endtask

    task automatic check_write(t_capture got);
        t_capture want;
        if (pending_writes.size() == 0) begin
            $error("write request with nothing expected, address %0h", got.addr);
            fails++;
            return;
        end
        want = pending_writes.pop_front();
        check_field("write_enable", SAMPLE_W'(want.we), SAMPLE_W'(got.we));
        check_field("write_bank", SAMPLE_W'(want.bank), SAMPLE_W'(got.bank));
        check_field("write_address", SAMPLE_W'(want.addr), SAMPLE_W'(got.addr));
        check_field("data_ch0", want.d0, got.d0);
        check_field("data_ch1", want.d1, got.d1);
        check_field("data_ch2", want.d2, got.d2);
        check_field("data_ch3", want.d3, got.d3);
        check_field("block_ready", SAMPLE_W'(want.ready), SAMPLE_W'(got.ready));
        check_field("ready_bank", SAMPLE_W'(want.rbank), SAMPLE_W'(got.rbank));
        check_field("block_dropped", SAMPLE_W'(want.dropped), SAMPLE_W'(got.dropped));
        n_checked++;
    endtask

    // one sample request, with an optional gap ahead of it
    task automatic feed_sample(t_sample_req r, bit known, t_capture want);
        t_capture pred;
        while ($urandom_range(0, 99) < src_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_sample_ch0    <= r.ch0;
        i_sample_ch1    <= r.ch1;
        i_sample_ch2    <= r.ch2;
        i_sample_ch3    <= r.ch3;
        i_consumer_idle <= r.idle;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pred = capture_step(r);
        pending_writes = {pending_writes, (known ? want : pred)};
        n_samples++;
        if (pred.we) n_writes++;
        if (pred.ready) n_handovers++;
        if (pred.dropped) n_drops++;
    endtask

    task automatic feed_random(int n);
        t_sample_req r;
        repeat (n) begin
            // idling mix moves on with the random request count
            if (rand_items < RAND_ITEMS / 3) begin
                src_gap_pct    = 34;
                sink_stall_pct = 71;
            end else if (rand_items < 2 * RAND_ITEMS / 3) begin
                src_gap_pct    = 71;
                sink_stall_pct = 34;
            end else begin
                src_gap_pct    = 0;
                sink_stall_pct = 0;
            end
            r.ch0  = $urandom();
            r.ch1  = $urandom();
            r.ch2  = $urandom();
            r.ch3  = $urandom();
            r.idle = 1'($urandom_range(0, 1));
            feed_sample(r, 1'b0, '0);
            rand_items++;
        end
    endtask

    // input channel quiet and every write request back
    task automatic quiesce();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_writes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_PERIOD_LENGTH:     cfg_per    = val[PERIOD_W-1:0];
            CFG_WINDOW_LENGTH:     cfg_win    = val[WIN_W-1:0];
            CFG_WINDOWS_PER_BLOCK: cfg_wpb    = val[WPB_W-1:0];
            default:               cfg_active = val[CHAN_W-1:0];
        endcase
        n_reg_writes++;
        @(posedge i_clk);
    endtask

    // output side: random stall, check every accepted write request
    initial begin : write_sink
        t_capture got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                got = {o_write_enable, o_write_bank, o_write_address, o_data_ch0, o_data_ch1,
                       o_data_ch2, o_data_ch3, o_block_ready, o_ready_bank, o_block_dropped};
                check_write(got);
            end
            i_stall <= ($urandom_range(0, 99) < sink_stall_pct);
        end
    end

    initial begin : watchdog
        #800_000;
        $display("timeout: write requests still outstanding: %0d", pending_writes.size());
        $display("TEST FAILED");
        $finish;
    end

    initial begin : main_seq
        logic [CFG_IDX_W-1:0]  reg_order [4];
        logic [CFG_DATA_W-1:0] val;
        int                    kind;
        int                    first;
        int                    phase;
        reg_order  = '{CFG_PERIOD_LENGTH, CFG_WINDOW_LENGTH, CFG_WINDOWS_PER_BLOCK,
                       CFG_ACTIVE_CHANNELS};
        cfg_per    = RST_PERIOD_LENGTH;
        cfg_win    = RST_WINDOW_LENGTH;
        cfg_wpb    = RST_WINDOWS_PER_BLOCK;
        cfg_active = RST_ACTIVE_CHANNELS;
        cap_pos    = '0;
        win_cnt    = '0;
        cur_bank   = 1'b0;

        // defaults after reset: first window samples at the bottom of bank 0
        add_sample({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1}, 1'b1,
                   write_of(1'b1, 1'b0, 23'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0));
        add_sample({32'h0, 32'h0, 32'h0, 32'h0, 1'b0}, 1'b1,
                   write_of(1'b1, 1'b0, 23'd1, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 1'b0));
        // lane masking
        add_reg(CFG_ACTIVE_CHANNELS, 20'd1);
        add_sample({32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h3C3C_3C3C, 32'hC3C3_C3C3, 1'b1}, 1'b1,
                   write_of(1'b1, 1'b0, 23'd2, 32'hA5A5_A5A5, 32'h0, 32'h0, 32'h0,
                            1'b0, 1'b0, 1'b0));
        add_reg(CFG_ACTIVE_CHANNELS, 20'd0);
        add_sample({32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210, 1'b0}, 1'b0, '0);
        add_reg(CFG_ACTIVE_CHANNELS, 20'd7);
        add_sample({32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'hFFFF_FFFE, 1'b1}, 1'b0, '0);
        add_reg(CFG_ACTIVE_CHANNELS, 20'd3);
        add_sample({32'hDEAD_BEEF, 32'hCAFE_F00D, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 1'b0}, 1'b0, '0);
        add_reg(CFG_ACTIVE_CHANNELS, 20'd2);
        add_sample({32'h1357_9BDF, 32'h2468_ACE0, 32'h1111_1111, 32'hEEEE_EEEE, 1'b1}, 1'b0, '0);
        // position already past the shortened period: skipped, then back to zero
        add_reg(CFG_WINDOW_LENGTH, 20'd2);
        add_reg(CFG_PERIOD_LENGTH, 20'd3);
        add_reg(CFG_WINDOWS_PER_BLOCK, 20'd2);
        add_sample({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1}, 1'b1,
                   write_of(1'b0, 1'b0, 23'd0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 1'b0));
        // two windows fill bank 0, consumer idle: hand-over and swap
        add_sample({32'h0000_FFFF, 32'hFFFF_0000, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0}, 1'b0, '0);
        add_sample({32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_FFFF, 32'hFFFF_0000, 1'b1}, 1'b0, '0);
        add_sample({32'h1234_5678, 32'h8765_4321, 32'h0F0F_F0F0, 32'hF0F0_0F0F, 1'b1}, 1'b0, '0);
        add_sample({32'h3333_3333, 32'hCCCC_CCCC, 32'h6666_6666, 32'h9999_9999, 1'b0}, 1'b0, '0);
        add_sample({32'h1, 32'h2, 32'h3, 32'h4, 1'b1}, 1'b1,
                   write_of(1'b1, 1'b0, 23'd3, 32'h1, 32'h2, 32'h0, 32'h0, 1'b1, 1'b0, 1'b0));
        add_sample({32'h7777_7777, 32'h8888_8888, 32'h1, 32'h2, 1'b0}, 1'b1,
                   write_of(1'b0, 1'b1, 23'd0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 1'b0));
        // bank 1 fills with the consumer busy: dropped, bank kept
        add_sample({32'hBEEF_0001, 32'hBEEF_0002, 32'hBEEF_0003, 32'hBEEF_0004, 1'b0}, 1'b0, '0);
        add_sample({32'hBEEF_0011, 32'hBEEF_0012, 32'hBEEF_0013, 32'hBEEF_0014, 1'b1}, 1'b0, '0);
        add_sample({32'hBEEF_0021, 32'hBEEF_0022, 32'hBEEF_0023, 32'hBEEF_0024, 1'b1}, 1'b0, '0);
        add_sample({32'hBEEF_0031, 32'hBEEF_0032, 32'hBEEF_0033, 32'hBEEF_0034, 1'b1}, 1'b0, '0);
        add_sample({32'h5, 32'h6, 32'h7, 32'h8, 1'b0}, 1'b1,
                   write_of(1'b1, 1'b1, 23'd3, 32'h5, 32'h6, 32'h0, 32'h0, 1'b0, 1'b0, 1'b1));
        // period shorter than the window: windows back to back
        add_reg(CFG_PERIOD_LENGTH, 20'd1);
        add_reg(CFG_WINDOW_LENGTH, 20'd3);
        add_sample({32'hC0DE_0001, 32'hC0DE_0002, 32'hC0DE_0003, 32'hC0DE_0004, 1'b0}, 1'b0, '0);
        add_sample({32'hC0DE_0011, 32'hC0DE_0012, 32'hC0DE_0013, 32'hC0DE_0014, 1'b0}, 1'b0, '0);
        add_sample({32'hC0DE_0021, 32'hC0DE_0022, 32'hC0DE_0023, 32'hC0DE_0024, 1'b1}, 1'b0, '0);
        add_sample({32'hC0DE_0031, 32'hC0DE_0032, 32'hC0DE_0033, 32'hC0DE_0034, 1'b1}, 1'b0, '0);
        // zero window length and zero block size both act as one
        add_reg(CFG_WINDOW_LENGTH, 20'd0);
        add_reg(CFG_WINDOWS_PER_BLOCK, 20'd0);
        add_sample({32'hF00D_0001, 32'hF00D_0002, 32'hF00D_0003, 32'hF00D_0004, 1'b0}, 1'b0, '0);
        add_sample({32'hF00D_0011, 32'hF00D_0012, 32'hF00D_0013, 32'hF00D_0014, 1'b1}, 1'b0, '0);
        // block size lowered to the running window count
        add_reg(CFG_WINDOWS_PER_BLOCK, 20'd4);
        add_sample({32'h0BAD_0001, 32'h0BAD_0002, 32'h0BAD_0003, 32'h0BAD_0004, 1'b1}, 1'b0, '0);
        add_sample({32'h0BAD_0011, 32'h0BAD_0012, 32'h0BAD_0013, 32'h0BAD_0014, 1'b0}, 1'b0, '0);
        add_reg(CFG_WINDOWS_PER_BLOCK, 20'd2);
        add_sample({32'h0BAD_0021, 32'h0BAD_0022, 32'h0BAD_0023, 32'h0BAD_0024, 1'b1}, 1'b0, '0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_REG) begin
                quiesce();
                set_reg(directed_rows[i].idx, directed_rows[i].val);
            end else begin
                feed_sample(directed_rows[i].req, directed_rows[i].known, directed_rows[i].want);
            end
        end

        // random phases, each with new register values
        phase = 0;
        while (rand_items < RAND_ITEMS) begin
            kind = (phase == 0) ? 8 : (phase == 1) ? 9 : $urandom_range(0, 19);
            quiesce();
            if (kind == 8) begin
                // one window per sample runs the window count up, then a wide
                // window pushes the address past the bank depth
                set_reg(CFG_PERIOD_LENGTH, 20'd1);
                set_reg(CFG_WINDOW_LENGTH, 20'd1);
                set_reg(CFG_WINDOWS_PER_BLOCK, 20'hFFFF);
                feed_random(150);
                quiesce();
                set_reg(CFG_WINDOW_LENGTH, 20'hFFFF);
                feed_random(20);
            end else if (kind == 9) begin
                // longest period; later phases cut it short under the position
                set_reg(CFG_PERIOD_LENGTH, 20'hFFFFF);
                set_reg(CFG_WINDOW_LENGTH, CFG_DATA_W'($urandom_range(1, 8)));
                feed_random(20);
            end else begin
                first = $urandom_range(0, 3);
                foreach (reg_order[k]) begin
                    if (k == first || $urandom_range(0, 1) == 1) begin
                        case (reg_order[k])
                            CFG_PERIOD_LENGTH:     val = CFG_DATA_W'($urandom_range(1, 12));
                            CFG_WINDOW_LENGTH:     val = CFG_DATA_W'($urandom_range(0, 8));
                            CFG_WINDOWS_PER_BLOCK: val = CFG_DATA_W'($urandom_range(0, 6));
                            default:               val = CFG_DATA_W'($urandom_range(0, 7));
                        endcase
                        set_reg(reg_order[k], val);
                    end
                end
                feed_random($urandom_range(20, 60));
            end
            phase++;
        end

        quiesce();
        if (pending_writes.size() != 0) begin
            $error("%0d write requests never arrived", pending_writes.size());
            fails++;
        end
        $display("sent %0d samples (%0d random) over %0d random phases and %0d register writes",
                 n_samples, rand_items, phase, n_reg_writes);
        $display("checked %0d write requests: %0d in window, %0d banks handed over, %0d dropped",
                 n_checked, n_writes, n_handovers, n_drops);
        if (fails == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/dccpp_pkg.sv
src/dccpp_front.sv
src/dccpp_queue.sv
src/dccpp_back.sv
src/duty_cycled_capture_ping_pong.sv
test/tb_duty_cycled_capture_ping_pong.sv
